@@ hdl/pfpcd_pkg.sv @@
// Shared types and constants for the parity-framed prefix-code decoder.
// No dependencies; imported by every module of the block but the trie RAM.
`timescale 1ns / 1ps
`default_nettype none

package pfpcd_pkg;

   // command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_FEED   = 2'd2;

   localparam int CODE_W     = 16;
   localparam int CODE_IDX_W = 4;
   localparam int LEN_W      = 5;
   localparam int SYM_W      = 8;
   localparam int FRAME_BITS = 9;
   localparam int DATA_BITS  = 8;
   localparam int CNT_W      = 16;

   localparam logic [CNT_W-1:0] MAX_SYMBOLS_RESET = 16'hFFFF;

   typedef struct packed {
      logic [1:0]        command;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
      logic [SYM_W-1:0]  code_symbol;
      logic [3:0]        hex_digit;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last_of_run;
   } rsp_type;

   // kept frame from the framer
   typedef struct packed {
      logic                 hit;
      logic [DATA_BITS-1:0] data;
   } frame_type;

   // result word handed from the sequencer to the output register
   typedef struct packed {
      logic    valid;
      rsp_type word;
   } push_type;

endpackage

`default_nettype wire

@@ hdl/pfpcd_trie_ram.sv @@
// Single-port-write, single-port-read synchronous RAM for trie nodes.
// Read data registered, with write-to-read forwarding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfpcd_trie_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/pfpcd_framer.sv @@
// Bit framer: expands hex digits MSB first into 9-bit frames, odd parity check.
// Depends on pfpcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfpcd_framer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 clear,
   input  wire logic                 feed,
   input  wire logic [3:0]           hex_digit,
   output pfpcd_pkg::frame_type      frame
);
   import pfpcd_pkg::*;

   logic [FRAME_BITS-2:0] shift_ff, shift_in;
   logic [3:0]            fill_ff, fill_in;
   logic [FRAME_BITS-1:0] acc;
   logic [FRAME_BITS-1:0] frm;
   logic [3:0]            cnt;
   logic                  done;

   // at most one frame closes per digit
   always_comb begin
      acc  = {1'b0, shift_ff};
      cnt  = fill_ff;
      frm  = '0;
      done = 1'b0;
      for (int i = 0; i < 4; i++) begin
         acc = {acc[FRAME_BITS-2:0], hex_digit[2'(3 - i)]};
         cnt = cnt + 4'd1;
         if (cnt == 4'(FRAME_BITS)) begin
            frm  = acc;
            done = 1'b1;
            acc  = '0;
            cnt  = '0;
         end
      end
      shift_in   = acc[FRAME_BITS-2:0];
      fill_in    = cnt;
      frame.hit  = done && (^frm);
      frame.data = frm[FRAME_BITS-1:1];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         shift_ff <= '0;
         fill_ff  <= '0;
      end else if (feed) begin
         shift_ff <= shift_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/pfpcd_seq.sv @@
// Trie sequencer: insert and walk by read-modify-write on the node RAM.
// Depends on pfpcd_pkg and pfpcd_trie_ram.
`timescale 1ns / 1ps
`default_nettype none

module pfpcd_seq #(
   parameter int TRIE_NODES   = 4096,
   parameter int MAX_CODE_LEN = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire pfpcd_pkg::req_type         req_word,
   input  wire pfpcd_pkg::frame_type       frame,
   input  wire logic [pfpcd_pkg::CNT_W-1:0] max_symbols,
   input  wire logic                       out_free,
   output pfpcd_pkg::push_type             push,
   output logic                            busy
);
   import pfpcd_pkg::*;

   localparam int NODE_W  = (TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1;
   localparam int FREE_W  = NODE_W + 1;
   localparam int ENTRY_W = 2 * NODE_W + SYM_W;
   localparam logic [LEN_W:0] MaxLen = (LEN_W + 1)'(MAX_CODE_LEN);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_INSERT,
      ST_WALK,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic                 fresh_ff, fresh_in;
   logic [LEN_W-1:0]     left_ff, left_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [SYM_W-1:0]     sym_ff, sym_in;
   logic [FREE_W-1:0]    next_free_ff, next_free_in;
   logic [NODE_W-1:0]    walk_node_ff, walk_node_in;
   logic                 check_ff, check_in;
   logic [3:0]           bit_cnt_ff, bit_cnt_in;
   logic [DATA_BITS-1:0] frame_ff, frame_in;
   logic [CNT_W-1:0]     sent_ff, sent_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]     pend_sym_ff, pend_sym_in;

   logic                 rd_en, wr_en;
   logic [NODE_W-1:0]    rd_addr, wr_addr;
   logic [ENTRY_W-1:0]   rd_data, wr_data;

   logic [NODE_W-1:0]    rd_c0, rd_c1, cur_c0, cur_c1, nxt, new_node;
   logic [SYM_W-1:0]     rd_sym, cur_sym;
   logic [LEN_W-1:0]     bidx;
   logic                 code_bit, walk_bit;
   logic                 len_ok;

   pfpcd_trie_ram #(
      .DEPTH (TRIE_NODES),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry layout: symbol | child1 | child0
   assign rd_c0  = rd_data[NODE_W-1:0];
   assign rd_c1  = rd_data[2*NODE_W-1:NODE_W];
   assign rd_sym = rd_data[ENTRY_W-1:2*NODE_W];

   // a node allocated by this insert is known all zero and is not read
   assign cur_c0  = fresh_ff ? '0 : rd_c0;
   assign cur_c1  = fresh_ff ? '0 : rd_c1;
   assign cur_sym = fresh_ff ? '0 : rd_sym;

   assign bidx     = left_ff - LEN_W'(1);
   assign code_bit = (bidx < LEN_W'(CODE_W)) ? code_ff[bidx[CODE_IDX_W-1:0]] : 1'b0;
   assign walk_bit = frame_ff[DATA_BITS-1];
   assign new_node = next_free_ff[NODE_W-1:0];
   assign len_ok   = (req_word.code_length != '0) &&
                     ({1'b0, req_word.code_length} <= MaxLen);

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      node_in       = node_ff;
      fresh_in      = fresh_ff;
      left_in       = left_ff;
      code_in       = code_ff;
      sym_in        = sym_ff;
      next_free_in  = next_free_ff;
      walk_node_in  = walk_node_ff;
      check_in      = check_ff;
      bit_cnt_in    = bit_cnt_ff;
      frame_in      = frame_ff;
      sent_in       = sent_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      push          = '0;
      nxt           = '0;

      case (state_ff)
         ST_INIT: begin
            // root entry zeroed; every other node is written before it is read
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_word.command)
                  CMD_CLEAR: begin
                     next_free_in = FREE_W'(1);
                     walk_node_in = '0;
                     sent_in      = '0;
                     state_in     = ST_INIT;
                  end
                  CMD_INSERT: begin
                     if (len_ok) begin
                        code_in  = req_word.code_bits;
                        sym_in   = req_word.code_symbol;
                        left_in  = req_word.code_length;
                        node_in  = '0;
                        fresh_in = 1'b0;
                        rd_en    = 1'b1;
                        state_in = ST_INSERT;
                     end
                  end
                  CMD_FEED: begin
                     if (frame.hit) begin
                        frame_in   = frame.data;
                        bit_cnt_in = '0;
                        check_in   = 1'b0;
                        rd_en      = 1'b1;
                        rd_addr    = walk_node_ff;
                        state_in   = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INSERT: begin
            wr_addr = node_ff;
            if (left_ff == '0) begin
               wr_en    = 1'b1;
               wr_data  = {sym_ff, cur_c1, cur_c0};
               state_in = ST_IDLE;
            end else begin
               nxt     = code_bit ? cur_c1 : cur_c0;
               left_in = bidx;
               if (nxt != '0) begin
                  node_in  = nxt;
                  fresh_in = 1'b0;
                  rd_en    = 1'b1;
                  rd_addr  = nxt;
               end else if (next_free_ff >= FREE_W'(TRIE_NODES)) begin
                  // table full: write back so a fresh node holds defined links
                  wr_en    = 1'b1;
                  wr_data  = {cur_sym, cur_c1, cur_c0};
                  state_in = ST_IDLE;
               end else begin
                  wr_en        = 1'b1;
                  wr_data      = code_bit ? {cur_sym, new_node, cur_c0}
                                          : {cur_sym, cur_c1, new_node};
                  node_in      = new_node;
                  fresh_in     = 1'b1;
                  next_free_in = next_free_ff + FREE_W'(1);
               end
            end
         end
         ST_WALK: begin
            if (check_ff && (rd_sym != '0)) begin
               if (sent_ff < max_symbols) begin
                  if (!pend_valid_ff || out_free) begin
                     push.valid       = pend_valid_ff;
                     push.word.symbol = pend_sym_ff;
                     pend_valid_in    = 1'b1;
                     pend_sym_in      = rd_sym;
                     sent_in          = sent_ff + CNT_W'(1);
                     walk_node_in     = '0;
                     check_in         = 1'b0;
                     rd_en            = 1'b1;
                  end
               end else begin
                  walk_node_in = '0;
                  check_in     = 1'b0;
                  rd_en        = 1'b1;
               end
            end else if (bit_cnt_ff == 4'(DATA_BITS)) begin
               state_in = ST_FLUSH;
            end else begin
               nxt          = walk_bit ? rd_c1 : rd_c0;
               frame_in     = {frame_ff[DATA_BITS-2:0], 1'b0};
               bit_cnt_in   = bit_cnt_ff + 4'd1;
               walk_node_in = nxt;
               check_in     = (nxt != '0);
               rd_en        = 1'b1;
               rd_addr      = nxt;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push.valid            = 1'b1;
               push.word.symbol      = pend_sym_ff;
               push.word.last_of_run = 1'b1;
               pend_valid_in         = 1'b0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         next_free_ff  <= FREE_W'(1);
         walk_node_ff  <= '0;
         sent_ff       <= '0;
         pend_valid_ff <= 1'b0;
         check_ff      <= 1'b0;
         bit_cnt_ff    <= '0;
         left_ff       <= '0;
         fresh_ff      <= 1'b0;
         node_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         walk_node_ff  <= walk_node_in;
         sent_ff       <= sent_in;
         pend_valid_ff <= pend_valid_in;
         check_ff      <= check_in;
         bit_cnt_ff    <= bit_cnt_in;
         left_ff       <= left_in;
         fresh_ff      <= fresh_in;
         node_ff       <= node_in;
      end
      code_ff     <= code_in;
      sym_ff      <= sym_in;
      frame_ff    <= frame_in;
      pend_sym_ff <= pend_sym_in;
   end

endmodule

`default_nettype wire

@@ hdl/parity_framed_prefix_code_decoder_top.sv @@
// Top level of the parity-framed prefix-code decoder: ports, limit register,
// output register. Depends on pfpcd_pkg, pfpcd_framer, pfpcd_seq.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a hex-digit bit stream against a binary trie of prefix codes.
// Each request word is a clear, an insert (code word + symbol) or a hex digit.
// Digits are shifted in MSB first and cut into 9-bit frames; a frame with an
// odd number of ones has its upper 8 bits walked through the trie, and every
// node with a symbol produces one response word (the last one of a request
// has last_of_run set). Output stops once csr_write_data's max_symbols count
// has been sent. The trie lives in a single RAM with one read and one write
// port, TRIE_NODES entries; node slots above the allocation pointer are never
// read, so no memory clearing pass is run.
// Request handling is limited by the single RAM read port. After reset, and
// again after a clear, the root entry is written before the next request is
// taken. An insert makes one RAM access per code bit; a digit that closes a
// kept frame makes one read per data bit plus one extra read per decoded
// symbol, and it also waits while rsp_stall holds the output register full.
// req_stall is high whenever a request is in progress. A result waits in the
// output register while the next request is taken.
module parity_framed_prefix_code_decoder_top #(
   parameter int TRIE_NODES   = 4096,
   parameter int MAX_CODE_LEN = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire pfpcd_pkg::req_type            req_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output pfpcd_pkg::rsp_type                 rsp_word,
   input  wire logic                          csr_write_en,
   input  wire logic [pfpcd_pkg::CNT_W-1:0]   csr_write_data
);
   import pfpcd_pkg::*;

   logic             busy;
   logic             accept;
   logic             out_free;
   frame_type        frame;
   push_type         push;
   logic [CNT_W-1:0] max_symbols_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_word_ff;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   // output register can take a word when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   pfpcd_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .clear     (accept && (req_word.command == CMD_CLEAR)),
      .feed      (accept && (req_word.command == CMD_FEED)),
      .hex_digit (req_word.hex_digit),
      .frame     (frame)
   );

   pfpcd_seq #(
      .TRIE_NODES   (TRIE_NODES),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_word    (req_word),
      .frame       (frame),
      .max_symbols (max_symbols_ff),
      .out_free    (out_free),
      .push        (push),
      .busy        (busy)
   );

   // limit register survives clear
   always_ff @(posedge clock) begin
      if (reset) begin
         max_symbols_ff <= MAX_SYMBOLS_RESET;
      end else if (csr_write_en) begin
         max_symbols_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (push.valid) begin
         rsp_word_ff <= push.word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

@@ hdl/pfpcd_checker.sv @@
// Port-level checks for the prefix-code decoder, bound to the top level.
// Depends on pfpcd_pkg and parity_framed_prefix_code_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module pfpcd_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire pfpcd_pkg::req_type          req_word,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire pfpcd_pkg::rsp_type          rsp_word
);
   import pfpcd_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // the root entry is written before any request is taken
   a_reset_busy: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken right after reset");

   // no request other than a digit starts a response
   a_no_rsp_ctrl: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_word.command != CMD_FEED)
      |=> !$rose(rsp_valid))
      else $error("response after a non-digit request");

   // a clear stalls the request port right after it (root entry rewrite)
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_word.command == CMD_CLEAR) |=> req_stall)
      else $error("request taken during clear");

endmodule

bind parity_framed_prefix_code_decoder_top pfpcd_checker u_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the parity-framed prefix-code decoder.
// Depends on pfpcd_pkg and parity_framed_prefix_code_decoder_top; a local trie model
// predicts every decoded symbol word.
`timescale 1ns / 1ps

module tb_top;
   import pfpcd_pkg::*;

   localparam int NODE_COUNT = 256;
   localparam int CODE_MAX   = 16;
   localparam int NODE_W     = 12;
   // command value the block must ignore
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // settle time covers the longest kept frame or insert, with margin
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int CYCLE_LIMIT   = 600000;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_stall;
   req_type          req_word       = '0;
   logic             rsp_valid;
   logic             rsp_stall      = 1'b0;
   rsp_type          rsp_word;
   logic             csr_write_en   = 1'b0;
   logic [CNT_W-1:0] csr_write_data = '0;

   parity_framed_prefix_code_decoder_top #(
      .TRIE_NODES  (NODE_COUNT),
      .MAX_CODE_LEN(CODE_MAX)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Trie model: two child links and a symbol per node, the partial frame,
   // the walk position and the emitted-symbol count.
   // ---------------------------------------------------------------------
   logic [1:0][NODE_W-1:0] trie_child  [NODE_COUNT];
   logic [SYM_W-1:0]       trie_symbol [NODE_COUNT];
   int unsigned            trie_free;
   logic [11:0]            frame_reg;
   int unsigned            frame_fill;
   logic [NODE_W-1:0]      walk_node;
   logic [CNT_W-1:0]       emitted;
   logic [CNT_W-1:0]       symbol_limit = MAX_SYMBOLS_RESET;

   // symbol words still owed by the block, oldest first
   rsp_type expected_symbols [$];

   int send_idle_pct = 34;
   int stall_pct     = 61;
   int errors        = 0;
   int items_sent    = 0;

   // stimulus side: bits waiting to be packed into digits, and code bits
   // waiting to be packed into frame data
   bit stream_bits [$];
   bit code_stream [$];

   function automatic void wipe_decoder();
      int n;
      for (n = 0; n < NODE_COUNT; n++) begin
         trie_child[n]  = '0;
         trie_symbol[n] = '0;
      end
      trie_free  = 1;
      frame_reg  = '0;
      frame_fill = 0;
      walk_node  = '0;
      emitted    = '0;
   endfunction

   function automatic void add_code(logic [CODE_W-1:0] bits, logic [LEN_W-1:0] len,
                                    logic [SYM_W-1:0] sym);
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] nxt;
      int                i;
      node = '0;
      if (len == 0 || int'(len) > CODE_MAX) return;
      for (i = int'(len); i > 0; i--) begin
         nxt = trie_child[node][bits[i-1]];
         if (nxt == 0) begin
            // out of nodes: path stops here, symbol never attached
            if (trie_free >= NODE_COUNT) return;
            nxt = NODE_W'(trie_free);
            trie_free++;
            trie_child[node][bits[i-1]] = nxt;
         end
         node = nxt;
      end
      trie_symbol[node] = sym;
   endfunction

   // Applies one accepted request word and queues the symbol words it owes.
   function automatic void decode_request(req_type w);
      rsp_type               run [$];
      rsp_type               word;
      logic [FRAME_BITS-1:0] frame;
      logic [NODE_W-1:0]     nxt;
      int                    i;
      int                    k;
      case (w.command)
         CMD_CLEAR:  wipe_decoder();
         CMD_INSERT: add_code(w.code_bits, w.code_length, w.code_symbol);
         CMD_FEED: begin
            for (i = 3; i >= 0; i--) begin
               frame_reg = {frame_reg[10:0], w.hex_digit[i]};
               frame_fill++;
               if (frame_fill >= FRAME_BITS) begin
                  frame = frame_reg[FRAME_BITS-1:0];
                  // odd parity keeps the frame; its top 8 bits walk the trie
                  if (^frame) begin
                     for (k = FRAME_BITS - 1; k >= 1; k--) begin
                        nxt       = trie_child[walk_node][frame[k]];
                        walk_node = nxt;   // missing branch lands on the root
                        if (nxt != 0 && trie_symbol[nxt] != 0) begin
                           walk_node = '0;
                           // past the limit the walk goes on silently
                           if (emitted < symbol_limit) begin
                              emitted++;
                              word.symbol      = trie_symbol[nxt];
                              word.last_of_run = 1'b0;
                              run.push_back(word);
                           end
                        end
                     end
                  end
                  frame_reg  = '0;
                  frame_fill = 0;
               end
            end
         end
         default: ;
      endcase
      for (i = 0; i < run.size(); i++) begin
         word             = run[i];
         word.last_of_run = (i == run.size() - 1);
         expected_symbols.push_back(word);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   function automatic req_type random_word(logic [1:0] cmd);
      req_type w;
      w.command     = cmd;
      w.code_bits   = CODE_W'($urandom);
      w.code_length = LEN_W'($urandom);
      w.code_symbol = SYM_W'($urandom);
      w.hex_digit   = 4'($urandom);
      return w;
   endfunction

   // Leaves req_valid high after acceptance; the next call either drives the
   // next word or idles, and wait_idle drops it.
   task automatic send_word(req_type w);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_request(w);
      if (w.command != CMD_UNUSED) items_sent++;
   endtask

   task automatic send_clear();
      send_word(random_word(CMD_CLEAR));
      stream_bits.delete();
      code_stream.delete();
   endtask

   task automatic send_insert(logic [CODE_W-1:0] bits, logic [LEN_W-1:0] len,
                              logic [SYM_W-1:0] sym);
      req_type w;
      w             = random_word(CMD_INSERT);
      w.code_bits   = bits;
      w.code_length = len;
      w.code_symbol = sym;
      send_word(w);
   endtask

   task automatic send_digit(logic [3:0] digit);
      req_type w;
      w           = random_word(CMD_FEED);
      w.hex_digit = digit;
      send_word(w);
   endtask

   // 8 data bits MSB first, then a parity bit that makes the frame odd (kept)
   // or even (dropped)
   function automatic void push_frame(logic [7:0] data, bit keep);
      int i;
      for (i = 7; i >= 0; i--) stream_bits.push_back(data[i]);
      stream_bits.push_back(keep ? ~^data : ^data);
   endfunction

   // sends whole digits; a remainder under four bits waits for more frames
   task automatic flush_digits();
      logic [3:0] digit;
      int         i;
      while (stream_bits.size() >= 4) begin
         for (i = 3; i >= 0; i--) digit[i] = stream_bits.pop_front();
         send_digit(digit);
      end
   endtask

   // drop valid, wait for owed words, then let an unproductive digit finish
   task automatic wait_idle();
      int c;
      req_valid <= 1'b0;
      c = 0;
      while (expected_symbols.size() != 0 && c < DRAIN_LIMIT) begin
         @(posedge clock);
         c++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [CNT_W-1:0] value);
      wait_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      symbol_limit    = value;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall, in-order compare against the model
   // ---------------------------------------------------------------------
   always @(posedge clock)
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin : check_symbols
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_symbols.size() == 0) begin
            $error("unexpected symbol word: symbol %02h last_of_run %0b",
                   rsp_word.symbol, rsp_word.last_of_run);
            errors++;
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_word.symbol !== want.symbol) begin
               $error("symbol: expected %02h, got %02h", want.symbol, rsp_word.symbol);
               errors++;
            end
            if (rsp_word.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b",
                      want.last_of_run, rsp_word.last_of_run);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Small code table, hand-built frames: a full run of eight symbols, a
   // dropped even frame, a 16-bit code spread over two frames, a missing
   // branch, a replaced symbol, ignored inserts and the unused command.
   task automatic test_basic_decode();
      send_clear();
      send_insert(16'h0007, 3, 8'h00);                    // 111: path only
      send_insert(16'hFFFF, 16, 8'h01);                   // longest code
      send_insert(CODE_W'($urandom & 32'hFFFE), 1, 8'h41);  // 0, junk above length
      send_insert(CODE_W'(($urandom & 32'hFFFC) | 32'h2), 2, 8'h42); // 10
      send_insert(CODE_W'(($urandom & 32'hFFF8) | 32'h6), 3, 8'hFF); // 110
      send_insert(16'h0006, 3, 8'h80);                    // 110 again, replaces
      send_insert(CODE_W'($urandom), 0, 8'hEE);           // bad lengths: ignored
      send_insert(CODE_W'($urandom), 17, 8'hEE);
      send_insert(CODE_W'($urandom), 31, 8'hEE);
      send_word(random_word(CMD_UNUSED));
      push_frame(8'h00, 1);          // eight 0x41
      push_frame(8'h00, 0);          // even parity, dropped
      push_frame(8'hFF, 1);          // halfway down the 16-bit code
      push_frame(8'hFF, 1);          // completes it
      push_frame(8'b1110_0101, 1);   // 111 then dead end, then 0, 10, 1...
      push_frame(8'b1011_0110, 1);
      push_frame(8'b0110_1100, 1);
      // leaves a partial frame in the block; the next clear discards it
      flush_digits();
   endtask

   // Output cap at zero, a small value and one; clear restarts the count.
   task automatic test_symbol_limit();
      logic [CNT_W-1:0] caps [3];
      int               i;
      caps = '{16'd0, 16'd3, 16'd1};
      for (i = 0; i < 3; i++) begin
         write_limit(caps[i]);
         send_clear();
         send_insert(16'h0000, 1, 8'h33);
         push_frame(8'h00, 1);
         push_frame(8'h00, 1);
         push_frame(8'h00, 1);
         flush_digits();
      end
   endtask

   // Fill all nodes with random 16-bit codes, then insert past capacity and
   // decode random frames through the full trie.
   task automatic test_trie_full();
      int tries;
      int i;
      send_clear();
      tries = 0;
      while (trie_free < NODE_COUNT && tries < 2000) begin
         send_insert(CODE_W'($urandom), LEN_W'(CODE_MAX),
                     SYM_W'($urandom_range(1, 255)));
         tries++;
      end
      send_insert(CODE_W'($urandom), LEN_W'(CODE_MAX), 8'h5A);   // new path cut short
      send_insert(CODE_W'($urandom), LEN_W'(CODE_MAX), 8'hA5);
      send_insert(16'h0000, 1, 8'h7E);          // existing node still takes it
      for (i = 0; i < 8; i++) push_frame(8'($urandom), 1);
      flush_digits();
   endtask

   // Random code tables with streams built from their codes; some noise:
   // corrupted frames, dropped frames, stray digits, random inserts, the
   // unused command, and tables kept across episodes.
   task automatic test_random_streams(int send_pct, int recv_pct,
                                      logic [CNT_W-1:0] cap, int count);
      logic [CODE_W-1:0] codes [8];
      logic [LEN_W-1:0]  lens  [8];
      logic [7:0]        data;
      int                stop;
      int                n;
      int                k;
      int                j;
      int                bit_pos;
      int                frames;
      write_limit(cap);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      stop          = items_sent + count;
      n             = 0;
      while (items_sent < stop) begin
         if (n == 0 || $urandom_range(7) != 0) begin
            send_clear();
            n = $urandom_range(2, 8);
            for (k = 0; k < n; k++) begin
               lens[k]  = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(7, CODE_MAX))
                                                   : LEN_W'($urandom_range(1, 5));
               codes[k] = CODE_W'($urandom);
               send_insert(codes[k], lens[k],
                           ($urandom_range(15) == 0) ? 8'd0
                                                     : SYM_W'($urandom_range(1, 255)));
            end
         end
         frames = $urandom_range(2, 6);
         for (k = 0; k < frames; k++) begin
            while (code_stream.size() < 8) begin
               j = $urandom_range(n - 1);
               for (bit_pos = int'(lens[j]); bit_pos > 0; bit_pos--)
                  code_stream.push_back(codes[j][bit_pos-1]);
            end
            for (j = 7; j >= 0; j--) data[j] = code_stream.pop_front();
            if ($urandom_range(9) == 0) data = 8'($urandom);
            push_frame(data, $urandom_range(5) != 0);
         end
         flush_digits();
         case ($urandom_range(5))
            0: send_word(random_word(CMD_UNUSED));
            1: send_word(random_word(CMD_INSERT));
            2: send_digit(4'($urandom));   // knocks the frame alignment off
            default: ;
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      wipe_decoder();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_basic_decode();
      test_symbol_limit();
      test_trie_full();
      test_random_streams(34, 61, 16'hFFFF, 30);
      test_random_streams(61, 34, CNT_W'($urandom_range(2, 12)), 30);
      test_random_streams(0, 0, CNT_W'($urandom_range(1, 16'hFFFF)), 30);

      wait_idle();
      if (expected_symbols.size() != 0) begin
         $error("%0d symbol words never arrived", expected_symbols.size());
         errors++;
      end
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

endmodule
